// ===== sv/b32e_pkg.sv =====
// Shared types, alphabet constants and the symbol lookup of the Base32 encoder.
`default_nettype none

package b32e_pkg;

    // Alphabet selector codes.
    localparam logic [2:0] ALPHA_UPPER = 3'd0;
    localparam logic [2:0] ALPHA_LOWER = 3'd1;
    localparam logic [2:0] ALPHA_ZBASE = 3'd2;
    localparam logic [2:0] ALPHA_HEX   = 3'd3;
    localparam logic [2:0] ALPHA_CROCK = 3'd4;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // First character of each string sits in the top byte.
    localparam logic [255:0] TAB_UPPER = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
    localparam logic [255:0] TAB_LOWER = "abcdefghijklmnopqrstuvwxyz234567";
    localparam logic [255:0] TAB_ZBASE = "ybndrfg8ejkmcpqxot1uwisza345h769";
    localparam logic [255:0] TAB_HEX   = "0123456789ABCDEFGHIJKLMNOPQRSTUV";
    localparam logic [255:0] TAB_CROCK = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";

    // One queued byte: its symbol indices (group symbols, then flush symbol),
    // how many of them there are, the index of its last result and the alphabet.
    typedef struct packed {
        logic [4:0] sym0;
        logic [4:0] sym1;
        logic [4:0] sym2;
        logic [1:0] nsym;
        logic [2:0] last_idx;
        logic [2:0] tbl;
        logic       fin;
    } t_b32e_desc;

    function automatic logic [7:0] b32e_char(input logic [2:0] tbl, input logic [4:0] idx);
        logic [255:0] tab;
        logic [4:0]   pos;
        case (tbl)
            ALPHA_LOWER: tab = TAB_LOWER;
            ALPHA_ZBASE: tab = TAB_ZBASE;
            ALPHA_HEX:   tab = TAB_HEX;
            ALPHA_CROCK: tab = TAB_CROCK;
            default:     tab = TAB_UPPER;
        endcase
        pos = 5'd31 - idx;
        return tab[{pos, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== sv/b32e_front.sv =====
// Front end: slices each byte into 5-bit groups and plans flush and padding.
`default_nettype none

module b32e_front
    import b32e_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_final_byte,
    input  wire logic [2:0] i_alphabet,
    output t_b32e_desc      o_desc
);

    logic [3:0] r_lb,    n_lb;
    logic [2:0] r_cnt,   n_cnt;
    logic [2:0] r_phase, n_phase;

    logic [11:0] acc;
    logic [11:0] sh0, sh1;
    logic [3:0]  c_full;
    logic [2:0]  c2, c3;
    logic        two, flush;
    logic [3:0]  lo_mask, lo;
    logic [4:0]  flush_sym;
    logic [1:0]  nsym;
    logic [2:0]  ph1, pad_raw, npad;
    logic [3:0]  room;
    logic [3:0]  total;
    logic [2:0]  tbl;

    always_comb begin
        tbl     = (i_alphabet > ALPHA_CROCK) ? ALPHA_UPPER : i_alphabet;
        acc     = {r_lb, i_data_byte};
        c_full  = {1'b0, r_cnt} + 4'd8;
        c2      = 3'(c_full - 4'd5);
        sh0     = acc >> c2;
        two     = (c2 >= 3'd5);
        sh1     = acc >> (c2 - 3'd5);
        c3      = two ? (c2 - 3'd5) : c2;
        lo_mask = 4'((5'd1 << c3) - 5'd1);
        lo      = acc[3:0] & lo_mask;
        flush   = i_final_byte && (c3 != 3'd0);
        flush_sym = 5'({1'b0, lo} << (3'd5 - c3));
        nsym    = 2'd1 + {1'b0, two} + {1'b0, flush};
        ph1     = r_phase + {1'b0, nsym};
        pad_raw = 3'd0 - ph1;
        room    = 4'd8 - {2'b00, nsym};
        if (!i_final_byte || tbl == ALPHA_ZBASE) begin
            npad = 3'd0;
        end else if ({1'b0, pad_raw} > room) begin
            npad = room[2:0];
        end else begin
            npad = pad_raw;
        end
        total = {2'b00, nsym} + {1'b0, npad};

        o_desc.sym0     = sh0[4:0];
        o_desc.sym1     = two ? sh1[4:0] : flush_sym;
        o_desc.sym2     = flush_sym;
        o_desc.nsym     = nsym;
        o_desc.last_idx = 3'(total - 4'd1);
        o_desc.tbl      = tbl;
        o_desc.fin      = i_final_byte;

        n_lb    = r_lb;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        if (i_fire) begin
            n_lb    = i_final_byte ? 4'd0 : lo;
            n_cnt   = i_final_byte ? 3'd0 : c3;
            n_phase = i_final_byte ? 3'd0 : ph1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lb    <= 4'd0;
            r_cnt   <= 3'd0;
            r_phase <= 3'd0;
        end else begin
            r_lb    <= n_lb;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("leftover count out of range");
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_final_byte) |=> (r_cnt == 3'd0 && r_lb == 4'd0 && r_phase == 3'd0))
        else $error("state not cleared after final byte");
`endif

endmodule

`default_nettype wire

// ===== sv/b32e_queue.sv =====
// Small descriptor queue between the front end and the symbol emitter.
`default_nettype none

module b32e_queue
    import b32e_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_b32e_desc i_desc,
    output logic            o_full,
    input  wire logic       i_pop,
    output t_b32e_desc      o_desc,
    output logic            o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_b32e_desc    r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_desc  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop) && !(i_pop && o_empty))
        else $error("queue overflow or underflow");
`endif

endmodule

`default_nettype wire

// ===== sv/b32e_back.sv =====
// Back end: walks one descriptor a symbol per cycle into the output register, unless stalled.
`default_nettype none

module b32e_back
    import b32e_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_b32e_desc i_desc,
    input  wire logic       i_empty,
    output logic            o_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_symbol_char,
    output logic            o_last_symbol
);

    logic [2:0] r_step, n_step;
    logic       r_valid, n_valid;
    logic [7:0] r_char, n_char;
    logic       r_last, n_last;
    logic       load;
    logic [4:0] idx;

    assign load = !i_empty && (!r_valid || i_out_ready);
    assign o_pop = load && (r_step == i_desc.last_idx);

    always_comb begin
        case (r_step)
            3'd0:    idx = i_desc.sym0;
            3'd1:    idx = i_desc.sym1;
            default: idx = i_desc.sym2;
        endcase
        n_step  = r_step;
        n_valid = r_valid && !i_out_ready;
        n_char  = r_char;
        n_last  = r_last;
        if (load) begin
            n_valid = 1'b1;
            n_char  = (r_step < {1'b0, i_desc.nsym}) ? b32e_char(i_desc.tbl, idx) : PAD_CHAR;
            n_last  = i_desc.fin && (r_step == i_desc.last_idx);
            n_step  = (r_step == i_desc.last_idx) ? 3'd0 : r_step + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_out_valid   = r_valid;
    assign o_symbol_char = r_char;
    assign o_last_symbol = r_last;

`ifndef SYNTHESIS
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_step <= i_desc.last_idx))
        else $error("symbol step ran past descriptor");
`endif

endmodule

`default_nettype wire

// ===== sv/base32_multi_alphabet_encoder.sv =====
// Top level of the streaming Base32 encoder with five selectable alphabets.
// A byte accepted by the front end is written into the queue, and its first symbol is then loaded
// into the output register. The front end takes a byte every cycle while the queue has room; the
// emitter puts out one symbol per cycle while the output is not stalled, so a byte yields one or
// two symbols and a final byte up to eight. Reset (synchronous, active low) clears the bit store,
// the symbol phase, the queue and the output beat, and selects the standard upper alphabet.
`default_nettype none

module base32_multi_alphabet_encoder
    import b32e_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration write channel.
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_alphabet_select,
    // Byte input channel.
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_final_byte,
    // Symbol output channel.
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_symbol_char,
    output logic            o_last_symbol
);

    // The alphabet register is always writable; the user is to write it only while the block is idle,
    // which the block does not enforce. Every byte is planned with the selection that stands when it arrives.
    logic [2:0] r_alphabet;

    t_b32e_desc front_desc;
    t_b32e_desc head_desc;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    logic       in_fire;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_full;
    assign in_fire     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet <= ALPHA_UPPER;
        end else if (i_cfg_valid) begin
            r_alphabet <= i_cfg_alphabet_select;
        end
    end

    // Front end: holds the leftover bits and symbol phase, and turns each byte into a
    // descriptor of its group symbols, optional flush symbol and padding count.
    b32e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (in_fire),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_alphabet   (r_alphabet),
        .o_desc       (front_desc)
    );

    // The queue lets the front keep taking bytes while the emitter works through padding
    // or waits on a stalled output.
    b32e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_fire),
        .i_desc  (front_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_desc  (head_desc),
        .o_empty (q_empty)
    );

    // Emitter: unless stalled, one symbol beat per cycle from the head descriptor into a registered output.
    b32e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_desc        (head_desc),
        .i_empty       (q_empty),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_symbol_char (o_symbol_char),
        .o_last_symbol (o_last_symbol)
    );

endmodule

`default_nettype wire

// ===== verif/base32_multi_alphabet_encoder_test.sv =====
// Self-checking testbench for the streaming Base32 encoder with five selectable alphabets.
module base32_multi_alphabet_encoder_test
    import b32e_pkg::*;
();

    // The run is cut off at this many cycles. A correct run needs only a small fraction of it.
    localparam int CYCLE_LIMIT = 500000;
    // After the last awaited symbol, watch the output a little longer for stray beats.
    localparam int TAIL_CYCLES = 8;
    localparam int RANDOM_BYTES = 350;

    // Symbol tables, first character in the top byte.
    localparam logic [255:0] SYMS_UPPER = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
    localparam logic [255:0] SYMS_LOWER = "abcdefghijklmnopqrstuvwxyz234567";
    localparam logic [255:0] SYMS_ZBASE = "ybndrfg8ejkmcpqxot1uwisza345h769";
    localparam logic [255:0] SYMS_HEX   = "0123456789ABCDEFGHIJKLMNOPQRSTUV";
    localparam logic [255:0] SYMS_CROCK = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";

    typedef struct {
        logic [7:0] symbol_char;
        logic       last_symbol;
    } t_symbol;

    // Ways the receiver paces its ready signal.
    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE
    } t_ready_mode;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [2:0] i_cfg_alphabet_select = ALPHA_UPPER;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_final_byte = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_cfg_ready;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_symbol_char;
    logic       o_last_symbol;

    // Mirror of the encoder state: bits not yet turned into a symbol, their count,
    // the symbol position within the current group of eight, and the alphabet.
    logic [3:0] model_spare_bits = 4'd0;
    logic [2:0] model_spare_count = 3'd0;
    logic [2:0] model_phase = 3'd0;
    logic [2:0] model_alphabet = ALPHA_UPPER;

    // Symbols that accepted bytes have earned but the output has not yet delivered.
    t_symbol awaited_symbols[$];

    int fail_count = 0;
    int cycle_count = 0;
    int bytes_sent = 0;
    int burst_left = 0;

    t_ready_mode ready_mode = READY_ALWAYS;
    int ready_stretch = 0;

    base32_multi_alphabet_encoder DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_alphabet_select (i_cfg_alphabet_select),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_data_byte           (i_data_byte),
        .i_final_byte          (i_final_byte),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_symbol_char         (o_symbol_char),
        .o_last_symbol         (o_last_symbol)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Map a 5-bit group to its ASCII symbol. Unused selector codes fall back to upper case.
    function automatic logic [7:0] symbol_of(input logic [2:0] sel, input logic [4:0] group);
        logic [255:0] syms;
        case (sel)
            ALPHA_LOWER: syms = SYMS_LOWER;
            ALPHA_ZBASE: syms = SYMS_ZBASE;
            ALPHA_HEX:   syms = SYMS_HEX;
            ALPHA_CROCK: syms = SYMS_CROCK;
            default:     syms = SYMS_UPPER;
        endcase
        return syms[(31 - int'(group)) * 8 +: 8];
    endfunction

    // Work out the symbols that one accepted byte causes and queue them in order.
    // Full groups come first; a final byte then adds a zero-filled flush symbol for any
    // spare bits and, except for z-base32, pads with '=' up to a multiple of eight.
    task automatic encode_byte(input logic [7:0] data, input logic fin);
        logic [11:0] acc;
        logic [2:0]  sel;
        int          cnt;
        int          n;
        t_symbol     syms[8];
        sel = (model_alphabet <= ALPHA_CROCK) ? model_alphabet : ALPHA_UPPER;
        acc = {model_spare_bits, data};
        cnt = int'(model_spare_count) + 8;
        n = 0;
        while (cnt >= 5) begin
            cnt -= 5;
            syms[n] = '{symbol_of(sel, 5'(acc >> cnt)), 1'b0};
            n++;
            model_phase = model_phase + 3'd1;
        end
        acc = acc & ((12'd1 << cnt) - 12'd1);
        if (!fin) begin
            model_spare_bits = acc[3:0];
            model_spare_count = 3'(cnt);
        end else begin
            if (cnt > 0) begin
                syms[n] = '{symbol_of(sel, 5'(acc << (5 - cnt))), 1'b0};
                n++;
                model_phase = model_phase + 3'd1;
            end
            if (sel != ALPHA_ZBASE) begin
                while (model_phase != 3'd0 && n < 8) begin
                    syms[n] = '{PAD_CHAR, 1'b0};
                    n++;
                    model_phase = model_phase + 3'd1;
                end
            end
            syms[n - 1].last_symbol = 1'b1;
            // A finished message leaves the encoder clean, whatever the alphabet.
            model_spare_bits = 4'd0;
            model_spare_count = 3'd0;
            model_phase = 3'd0;
        end
        for (int k = 0; k < n; k++) awaited_symbols.push_back(syms[k]);
    endtask

    // Offer one byte and hold it until it is taken. The sender works in bursts: when a
    // burst is used up, valid may drop for a random gap and a new burst length is drawn.
    // Valid is left high after a beat so that back-to-back bytes need no second edit.
    task automatic send_byte(input logic [7:0] data, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_data_byte  <= data;
        i_final_byte <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        encode_byte(data, fin);
        bytes_sent++;
    endtask

    // Random bytes, the last one flagged as the end of the message.
    task automatic send_message(input int len);
        for (int k = 0; k < len; k++) send_byte(8'($urandom), k == len - 1);
    endtask

    // Stop offering bytes and wait until every awaited symbol has come out. Since every
    // byte yields at least one symbol, an empty list means the encoder is idle. The wait
    // always takes a clock edge, so a following raise of valid lands in a later time step.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_symbols.size() != 0);
    endtask

    // One beat on the configuration channel. Only called while the encoder is idle.
    task automatic write_alphabet(input logic [2:0] sel);
        i_cfg_valid           <= 1'b1;
        i_cfg_alphabet_select <= sel;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        model_alphabet = sel;
    endtask

    // The reset alphabet is standard upper case. All-zero and all-one single-byte
    // messages give the extremes of the symbol index and the longest padding run.
    task automatic test_reset_alphabet_extremes();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        wait_for_drain();
    endtask

    // Every selector code, the unused ones included. The message lengths 1 to 5 cover every
    // amount of padding but that of three bytes, which falls on the z-base32 run and shows it left out.
    task automatic test_each_alphabet();
        for (int sel = 0; sel < 8; sel++) begin
            write_alphabet(3'(sel));
            send_message((sel < 5) ? sel + 1 : 1);
            wait_for_drain();
        end
    endtask

    // A new alphabet takes effect between bytes of the same message, and padding
    // follows the alphabet in force at the final byte: none after switching to z-base32.
    task automatic test_switch_mid_message();
        write_alphabet(ALPHA_UPPER);
        send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b0);
        wait_for_drain();
        write_alphabet(ALPHA_ZBASE);
        send_byte(8'($urandom), 1'b1);
        wait_for_drain();
        write_alphabet(ALPHA_HEX);
        send_byte(8'($urandom), 1'b0);
        wait_for_drain();
        write_alphabet(ALPHA_LOWER);
        send_byte(8'($urandom), 1'b1);
        wait_for_drain();
    endtask

    // Random messages of random length, mostly short. Between messages the sender now
    // and then waits for the output to empty and may pick a new alphabet; sometimes the
    // alphabet is changed in the middle of a message as well.
    task automatic test_random_messages();
        int start;
        int len;
        int split;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            len = ($urandom_range(0, 6) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            if (len > 1 && $urandom_range(0, 9) == 0) begin
                split = $urandom_range(1, len - 1);
                for (int k = 0; k < split; k++) send_byte(8'($urandom), 1'b0);
                wait_for_drain();
                write_alphabet(3'($urandom_range(0, 7)));
                for (int k = split; k < len; k++) send_byte(8'($urandom), k == len - 1);
            end else begin
                send_message(len);
            end
            if ($urandom_range(0, 3) == 0) begin
                wait_for_drain();
                if ($urandom_range(0, 1) == 0) write_alphabet(3'($urandom_range(0, 7)));
            end
        end
        wait_for_drain();
    endtask

    // Receiver pacing: each stretch of cycles picks one mode, from never stalling to
    // letting only about one beat in eight through.
    always @(posedge i_clk) begin
        if (ready_stretch == 0) begin
            ready_mode    <= t_ready_mode'($urandom_range(0, 2));
            ready_stretch <= $urandom_range(20, 200);
        end else begin
            ready_stretch <= ready_stretch - 1;
        end
        case (ready_mode)
            READY_ALWAYS: i_out_ready <= 1'b1;
            READY_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            default:      i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Every output beat is matched against the oldest awaited symbol.
    always @(posedge i_clk) begin
        t_symbol want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_symbols.size() == 0) begin
                $error("symbol %h arrived with none awaited", o_symbol_char);
                fail_count++;
            end else begin
                want = awaited_symbols.pop_front();
                if (o_symbol_char !== want.symbol_char) begin
                    $error("symbol_char: expected %h, got %h", want.symbol_char, o_symbol_char);
                    fail_count++;
                end
                if (o_last_symbol !== want.last_symbol) begin
                    $error("last_symbol: expected %b, got %b", want.last_symbol, o_last_symbol);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_alphabet_extremes();
        test_each_alphabet();
        test_switch_mid_message();
        test_random_messages();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (awaited_symbols.size() != 0) begin
            $error("%0d symbols never arrived", awaited_symbols.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
